// ----- sv/assert_macros.svh -----
// Assertion macros used by the supply setpoint monitor core.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is skipped while reset is high.
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clock, reset, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clock, prop, msg)

`endif

`endif

// ----- sv/ssm_pkg.sv -----
// Shared types and constants for the supply setpoint stability monitor.
// No dependencies; every RTL module and interface of the block imports this package.
`timescale 1ns / 1ps

package ssm_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_RESTORE = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_ACK     = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SETPT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SETPT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE_LIM = 3'd5;

  // Register reset values.
  localparam logic [7:0]  RST_STEP_SIZE    = 8'd50;
  localparam logic [13:0] RST_MAX_SETPT    = 14'd12000;
  localparam logic [13:0] RST_MIN_SETPT    = 14'd660;
  localparam logic [7:0]  RST_CALIBRATION  = 8'd30;
  localparam logic [7:0]  RST_TOLERANCE    = 8'd20;
  localparam logic [7:0]  RST_UNSTABLE_LIM = 8'd12;

  // ADC counts to millivolts.
  localparam logic [4:0]  ADC_SCALE = 5'd20;
  localparam logic [7:0]  CNT_MAX   = 8'd255;

  typedef struct packed {
    logic [7:0]  step_size_mv;
    logic [13:0] max_setpoint_mv;
    logic [13:0] min_setpoint_mv;
    logic [7:0]  calibration_mv;
    logic [7:0]  tolerance_mv;
    logic [7:0]  unstable_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [13:0]       saved_setpoint_mv;
    logic              encoder_moved;
    logic signed [6:0] encoder_delta;
    logic [9:0]        adc_sample;
  } item_t;

  typedef struct packed {
    logic [13:0] setpoint_mv;
    logic        dac_write;
    logic [14:0] measured_mv;
    logic        stable;
    logic        dirty;
  } result_t;

endpackage

// ----- sv/ssm_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on ssm_pkg only for consistency of the field widths.
`timescale 1ns / 1ps

interface ssm_item_if import ssm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [13:0]       saved_setpoint_mv;
  logic              encoder_moved;
  logic signed [6:0] encoder_delta;
  logic [9:0]        adc_sample;

  modport source (output valid, op, saved_setpoint_mv, encoder_moved, encoder_delta,
                  adc_sample, input ready);
  modport sink (input valid, op, saved_setpoint_mv, encoder_moved, encoder_delta,
                adc_sample, output ready);
endinterface

interface ssm_result_if import ssm_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [13:0] setpoint_mv;
  logic        dac_write;
  logic [14:0] measured_mv;
  logic        stable;
  logic        dirty;

  modport source (output valid, setpoint_mv, dac_write, measured_mv, stable, dirty,
                  input ready);
  modport sink (input valid, setpoint_mv, dac_write, measured_mv, stable, dirty,
                output ready);
endinterface

// ----- sv/ssm_cfg.sv -----
// Configuration register file of the supply setpoint monitor.
// Depends on ssm_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module ssm_cfg
  import ssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size_mv    <= RST_STEP_SIZE;
      cfg.max_setpoint_mv <= RST_MAX_SETPT;
      cfg.min_setpoint_mv <= RST_MIN_SETPT;
      cfg.calibration_mv  <= RST_CALIBRATION;
      cfg.tolerance_mv    <= RST_TOLERANCE;
      cfg.unstable_limit  <= RST_UNSTABLE_LIM;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_STEP_SIZE:    cfg.step_size_mv    <= cfg_data[7:0];
        REG_MAX_SETPT:    cfg.max_setpoint_mv <= cfg_data[13:0];
        REG_MIN_SETPT:    cfg.min_setpoint_mv <= cfg_data[13:0];
        REG_CALIBRATION:  cfg.calibration_mv  <= cfg_data[7:0];
        REG_TOLERANCE:    cfg.tolerance_mv    <= cfg_data[7:0];
        REG_UNSTABLE_LIM: cfg.unstable_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/ssm_core.sv -----
// Setpoint, measurement and stability state with its one-step update logic.
// Depends on ssm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssm_core
  import ssm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  logic [13:0] setpoint;
  logic [14:0] measured;   // also serves as the previous measurement
  logic [7:0]  unstable_cnt;
  logic        stable_flag;
  logic        dirty_flag;

  logic [13:0] setpoint_next;
  logic [14:0] measured_next;
  logic [7:0]  unstable_cnt_next;
  logic        stable_next;
  logic        dirty_next;
  logic        dac_next;

  logic signed [15:0] change;
  logic [15:0]        change_neg;
  logic [16:0]        sum_up;
  logic [13:0]        diff_dn;
  logic [13:0]        enc_setpoint;
  logic [14:0]        sample_mv;
  logic [14:0]        jump;
  logic [14:0]        error;
  logic [7:0]         cnt_once;
  logic [7:0]         cnt_twice;

  // Encoder path: signed product, then clamp.
  always_comb begin
    change     = $signed({1'b0, cfg.step_size_mv}) * item.encoder_delta;
    change_neg = 16'(-change);
    sum_up     = {3'b000, setpoint} + {1'b0, change};
    diff_dn    = setpoint - change_neg[13:0];
    if (change > 16'sd0) begin
      if (sum_up > {3'b000, cfg.max_setpoint_mv}) begin
        enc_setpoint = cfg.max_setpoint_mv;
      end else begin
        enc_setpoint = sum_up[13:0];
      end
    end else if (change_neg > {2'b00, setpoint}) begin
      enc_setpoint = cfg.min_setpoint_mv;
    end else if (diff_dn < cfg.min_setpoint_mv) begin
      enc_setpoint = cfg.min_setpoint_mv;
    end else begin
      enc_setpoint = diff_dn;
    end
  end

  // Sample path: times 20 as two shifts, plus the calibration offset.
  always_comb begin
    sample_mv = 15'({item.adc_sample, 4'b0000}) + 15'({item.adc_sample, 2'b00})
              + 15'(cfg.calibration_mv);
    jump  = (measured > sample_mv) ? measured - sample_mv : sample_mv - measured;
    error = ({1'b0, setpoint} > sample_mv) ? {1'b0, setpoint} - sample_mv
                                           : sample_mv - {1'b0, setpoint};
    cnt_once  = (unstable_cnt == CNT_MAX) ? CNT_MAX : unstable_cnt + 8'd1;
    cnt_twice = (cnt_once == CNT_MAX) ? CNT_MAX : cnt_once + 8'd1;
  end

  always_comb begin
    setpoint_next     = setpoint;
    measured_next     = measured;
    unstable_cnt_next = unstable_cnt;
    stable_next       = stable_flag;
    dirty_next        = dirty_flag;
    dac_next          = 1'b0;
    case (item.op)
      OP_RESTORE: begin
        setpoint_next = item.saved_setpoint_mv;
        dac_next      = 1'b1;
      end
      OP_TICK: begin
        if (item.encoder_moved) begin
          setpoint_next = enc_setpoint;
          dirty_next    = 1'b1;
          dac_next      = 1'b1;
        end else begin
          measured_next = sample_mv;
          if (jump > {7'd0, cfg.tolerance_mv}) begin
            dirty_next = 1'b1;
          end
          if (error > {7'd0, cfg.tolerance_mv}) begin
            // Out of tolerance: the counter moves up by two, and the limit is
            // checked after the first step.
            if (cnt_once > cfg.unstable_limit && stable_flag) begin
              stable_next = 1'b0;
              dirty_next  = 1'b1;
            end
            unstable_cnt_next = cnt_twice;
            dac_next          = 1'b1;
          end else if (unstable_cnt != 8'd0) begin
            unstable_cnt_next = unstable_cnt - 8'd1;
          end else if (!stable_flag) begin
            stable_next = 1'b1;
            dirty_next  = 1'b1;
          end
        end
      end
      OP_ACK: begin
        dirty_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= '0;
      measured     <= '0;
      unstable_cnt <= '0;
      stable_flag  <= 1'b0;
      dirty_flag   <= 1'b0;
    end else if (fire) begin
      setpoint     <= setpoint_next;
      measured     <= measured_next;
      unstable_cnt <= unstable_cnt_next;
      stable_flag  <= stable_next;
      dirty_flag   <= dirty_next;
    end
  end

  assign res.setpoint_mv = setpoint_next;
  assign res.dac_write   = dac_next;
  assign res.measured_mv = measured_next;
  assign res.stable      = stable_next;
  assign res.dirty       = dirty_next;

  `ASSERT_CLK(a_state_holds_when_idle, clk, rst, !fire |=> $stable(setpoint) && $stable(unstable_cnt) && $stable(measured), "state changed without a transaction")
  `ASSERT_CLK(a_restore_loads, clk, rst, fire && item.op == OP_RESTORE |=> setpoint == $past(item.saved_setpoint_mv), "restore did not load the saved setpoint")
  `ASSERT_CLK(a_ack_clears_dirty, clk, rst, fire && item.op == OP_ACK |=> !dirty_flag, "ack left the dirty flag set")
  `ASSERT_CLK(a_dac_only_on_update, clk, rst, res.dac_write |-> item.op == OP_RESTORE || item.op == OP_TICK, "DAC write on an item that does not update")
  `ASSERT_CLK_ALWAYS(a_reset_clears, clk, $past(rst) |-> !stable_flag && !dirty_flag && unstable_cnt == 8'd0, "state not cleared by reset")

endmodule

// ----- sv/supply_setpoint_stability_monitor.sv -----
// Supply setpoint stability monitor: input register, update core, result register.
// Depends on ssm_pkg, ssm_if, ssm_cfg and ssm_core.
`timescale 1ns / 1ps

// Takes one item per clock while results are being taken, and returns one result
// per item. An accepted transaction waits in the input register; the update logic
// writes the new state and the result register together at an edge when the
// result register is free or being read, so items may follow every cycle while
// results are taken. The result register is one deep: while it holds a result that
// is not taken, the input register can still take one more item, after which input
// ready drops until the result side moves. Configuration writes take effect at the
// next edge and must only be made while no items are in flight.
module supply_setpoint_stability_monitor
  import ssm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ssm_item_if.sink              item,
  ssm_result_if.source          result
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid;
  logic    out_valid;
  result_t out_q;
  result_t res_next;
  logic    advance;

  assign advance    = item_valid && (!out_valid || result.ready);
  assign item.ready = !item_valid || advance;

  ssm_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  ssm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (item_q),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      item_q.op                <= item.op;
      item_q.saved_setpoint_mv <= item.saved_setpoint_mv;
      item_q.encoder_moved     <= item.encoder_moved;
      item_q.encoder_delta     <= item.encoder_delta;
      item_q.adc_sample        <= item.adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_q <= res_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.setpoint_mv = out_q.setpoint_mv;
  assign result.dac_write   = out_q.dac_write;
  assign result.measured_mv = out_q.measured_mv;
  assign result.stable      = out_q.stable;
  assign result.dirty       = out_q.dirty;

endmodule
